// File: hdl/lms_adaptive_fir_macros.svh
// ----------------------------------------------------------------------------
// LMS adaptive FIR assertion macros
// Shared helpers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_FIR_MACROS_SVH
`define LMS_ADAPTIVE_FIR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define LAFIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define LAFIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lafir_pkg.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR package
// Field widths, register indexes and the command and status bundles that
// join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lafir_pkg;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int ERR_W    = 17;
    localparam int WEIGHT_W = 32;
    localparam int GAIN_W   = 16;
    localparam int SHIFT_W  = 6;
    localparam int FRAC_W   = 24;

    // Gain times error, and that times a sample.
    localparam int GE_W   = GAIN_W + 1 + ERR_W;
    localparam int PROD_W = GE_W + SAMPLE_W;
    // Rounded product before the shift; one guard bit and one for the round term.
    localparam int SUM_W  = PROD_W + 2;

    // Any shift above this leaves a zero weight delta.
    localparam logic [SHIFT_W-1:0] SHIFT_LIMIT = SHIFT_W'(PROD_W);

    // Stream and configuration widths.
    localparam int IN_W      = 2 * SAMPLE_W;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = GAIN_W;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SHIFT = 2'd1;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd3;

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_wr;   // write zero to both memories at the tap counter
        logic load;       // take the input beat, store the sample
        logic issue;      // read one tap and send it down the pipeline
        logic upd_mode;   // the issued tap belongs to the weight update sweep
        logic rewind;     // return the history pointer to the newest sample
        logic finish;     // round y, form the error, load the output register
        logic gain_mul;   // form gain times error
        logic head_adv;   // move the delay line head on by one slot
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic last;       // tap counter stands at the final tap
        logic pipe_busy;  // a tap is still in the pipeline
        logic out_busy;   // the output register holds a beat that is not taken
    } sts_t;

endpackage

`default_nettype wire

// File: hdl/lms_adaptive_fir.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR filter
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
// Each input beat carries a reference sample and a desired sample; each output
// beat carries the filter output y (formed with the weights from before this
// beat's update, rounded and saturated to 16 bits) and the error desired - y.
// One multiplier is shared by all taps: it sweeps the TAPS taps once for the
// output and once more for the weight update, and the next ready waits for
// both sweeps, plus any time the previous output beat is left waiting when
// the new result is ready. After reset a clearing pass writes zeros to the
// weight and sample memories, during which no input beat is taken;
// configuration writes are taken at any time but should only be made while
// the block is idle. The step size is step_gain * 2^-(step_shift+24).
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir #(
    parameter int TAPS = 500
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [15:0] input_sample, [31:16] desired_sample
    input  wire logic [lafir_pkg::IN_W-1:0]          s_axis_tdata,
    // Output stream.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] filter_out, [32:16] error_out, [39:33] zero
    output logic      [lafir_pkg::OUT_W-1:0]         m_axis_tdata,
    // Configuration port: index 0 step_gain, index 1 step_shift.
    input  wire logic                                cfg_we,
    input  wire logic [lafir_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [lafir_pkg::CFG_W-1:0]         cfg_wdata
);

    lafir_pkg::cmd_t cmd;
    lafir_pkg::sts_t sts;

    lafir_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lafir_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hdl/lafir_ram.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lafir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 500
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/lafir_ctrl.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR controller
// Sequences the clearing pass, the filter sweep, the result, and the
// weight update sweep over the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lms_adaptive_fir_macros.svh"

module lafir_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire lafir_pkg::sts_t   sts,
    output lafir_pkg::cmd_t        cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_FILTER = 8'b0000_0100,
        ST_FDRAIN = 8'b0000_1000,
        ST_RESULT = 8'b0001_0000,
        ST_GAIN   = 8'b0010_0000,
        ST_UPDATE = 8'b0100_0000,
        ST_UDRAIN = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER:
            begin
                cmd.issue = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_FDRAIN;
                end
            end
            ST_FDRAIN:
            begin
                // Wait for the last product and for room in the output register.
                if (!sts.pipe_busy && !sts.out_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                cmd.finish = 1'b1;
                cmd.rewind = 1'b1;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.gain_mul = 1'b1;
                state_next   = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.issue    = 1'b1;
                cmd.upd_mode = 1'b1;
                if (sts.last)
                begin
                    state_next = ST_UDRAIN;
                end
            end
            ST_UDRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    cmd.head_adv = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // A new sample enters only with the pipeline empty.
    `LAFIR_ASSERT_NOW(a_accept_idle, in_ready, !sts.pipe_busy, "beat accepted with taps in flight")
    // The result never overwrites an output beat that is still waiting.
    `LAFIR_ASSERT_NOW(a_finish_free, cmd.finish, !sts.out_busy, "output beat overwritten")
    // Gain times error changes only while no update product is in flight.
    `LAFIR_ASSERT_NOW(a_gain_quiet, cmd.gain_mul, !sts.pipe_busy, "step product changed mid-sweep")
    // The update sweep ends after the final tap.
    `LAFIR_ASSERT_NEXT(a_upd_end, (state_reg == ST_UPDATE) && sts.last,
        state_reg == ST_UDRAIN, "update sweep overran the taps")

endmodule

`default_nettype wire

// File: hdl/lafir_dp.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR datapath
// Weight and sample memories, tap counters, the shared multiplier, the
// accumulator, the weight update pipeline and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lafir_dp #(
    parameter int TAPS = 500
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lafir_pkg::cmd_t                     cmd,
    output lafir_pkg::sts_t                          sts,
    input  wire logic                                cfg_we,
    input  wire logic [lafir_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [lafir_pkg::CFG_W-1:0]         cfg_wdata,
    input  wire logic [lafir_pkg::IN_W-1:0]          in_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [lafir_pkg::OUT_W-1:0]         out_data
);

    localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [ADDR_W-1:0] K_LAST = ADDR_W'(TAPS - 1);
    localparam int ACC_W  = lafir_pkg::PROD_W + ADDR_W;
    localparam int YF_W   = ACC_W - lafir_pkg::FRAC_W;
    localparam int SW     = lafir_pkg::SAMPLE_W;
    localparam int WW     = lafir_pkg::WEIGHT_W;
    localparam int EW     = lafir_pkg::ERR_W;
    localparam int SUMW   = lafir_pkg::SUM_W;
    localparam int IN_W_HI = lafir_pkg::IN_W - 1;

    // Step size registers.
    logic [lafir_pkg::GAIN_W-1:0]  gain_reg;
    logic [lafir_pkg::SHIFT_W-1:0] shift_reg;

    // Tap counter, history pointer, delay line head.
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] head_reg, head_next;

    // Pipeline control.
    logic              v1_reg, v2_reg, v3_reg;
    logic              m1_reg, m2_reg, m3_reg;
    logic [ADDR_W-1:0] k1_reg, k2_reg, k3_reg;

    // Payload registers.
    logic signed [SW-1:0]                d_reg;
    logic signed [WW-1:0]                w2_reg, w3_reg;
    logic signed [lafir_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUMW-1:0]              delta_reg, delta_next;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [lafir_pkg::GE_W-1:0]   ge_reg, ge_next;
    logic signed [SW-1:0]                y_reg, y_next;
    logic signed [EW-1:0]                e_reg, e_next;
    logic                                out_valid_reg;

    // Memory ports.
    logic              w_we, h_we;
    logic [ADDR_W-1:0] w_waddr, h_waddr;
    logic [WW-1:0]     w_wdata, w_rd;
    logic [SW-1:0]     h_wdata, h_rd;

    // Arithmetic intermediates.
    logic signed [lafir_pkg::GE_W-1:0] mul_a;
    logic signed [SUMW-1:0]            rnd;
    logic signed [SUMW-1:0]            psum;
    logic signed [SUMW:0]              wsum;
    logic signed [WW-1:0]              wsat;
    logic signed [ACC_W-1:0]           acc_rnd;
    logic signed [YF_W-1:0]            yfull;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= lafir_pkg::GAIN_RESET;
            shift_reg <= lafir_pkg::SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == lafir_pkg::CFG_STEP_GAIN)
            begin
                gain_reg <= cfg_wdata;
            end
            else if (cfg_addr == lafir_pkg::CFG_STEP_SHIFT)
            begin
                shift_reg <= cfg_wdata[lafir_pkg::SHIFT_W-1:0];
            end
        end
    end

    // Counters: the tap counter wraps to zero after the final tap, and the
    // history pointer walks backward from the newest sample.
    always_comb
    begin
        k_next    = k_reg;
        ptr_next  = ptr_reg;
        head_next = head_reg;
        if (cmd.clear_wr || cmd.issue)
        begin
            k_next = (k_reg == K_LAST) ? '0 : k_reg + 1'b1;
        end
        if (cmd.load || cmd.rewind)
        begin
            ptr_next = head_reg;
        end
        else if (cmd.issue)
        begin
            ptr_next = (ptr_reg == '0) ? K_LAST : ptr_reg - 1'b1;
        end
        if (cmd.head_adv)
        begin
            head_next = (head_reg == K_LAST) ? '0 : head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg    <= '0;
            ptr_reg  <= '0;
            head_reg <= '0;
        end
        else
        begin
            k_reg    <= k_next;
            ptr_reg  <= ptr_next;
            head_reg <= head_next;
        end
    end

    // Memory write ports: zero fill during the clearing pass, the new sample
    // on accept, and updated weights from the end of the pipeline.
    always_comb
    begin
        h_we    = cmd.clear_wr || cmd.load;
        h_waddr = cmd.clear_wr ? k_reg : head_reg;
        h_wdata = cmd.clear_wr ? '0 : in_data[SW-1:0];
        w_we    = cmd.clear_wr || (v3_reg && m3_reg);
        w_waddr = cmd.clear_wr ? k_reg : k3_reg;
        w_wdata = cmd.clear_wr ? '0 : wsat;
    end

    lafir_ram #(
        .WIDTH (WW),
        .DEPTH (TAPS)
    ) u_weights (
        .clk     (clk),
        .we      (w_we),
        .wr_addr (w_waddr),
        .wr_data (w_wdata),
        .rd_addr (k_reg),
        .rd_data (w_rd)
    );

    lafir_ram #(
        .WIDTH (SW),
        .DEPTH (TAPS)
    ) u_history (
        .clk     (clk),
        .we      (h_we),
        .wr_addr (h_waddr),
        .wr_data (h_wdata),
        .rd_addr (ptr_reg),
        .rd_data (h_rd)
    );

    // Pipeline valid, mode and tap address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            m1_reg <= 1'b0;
            m2_reg <= 1'b0;
            m3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            m1_reg <= cmd.upd_mode;
            m2_reg <= m1_reg;
            m3_reg <= m2_reg;
        end
    end

    // Shared multiplier: weight times sample for the filter sweep, gain
    // times error times sample for the update sweep.
    always_comb
    begin
        mul_a     = m1_reg ? ge_reg
                           : {{(lafir_pkg::GE_W - WW){w_rd[WW-1]}}, $signed(w_rd)};
        prod_next = mul_a * $signed(h_rd);
    end

    // Round half up and shift the update product.
    always_comb
    begin
        rnd  = $signed((SUMW'(1) << shift_reg) >> 1);
        psum = $signed({{(SUMW - lafir_pkg::PROD_W){prod_reg[lafir_pkg::PROD_W-1]}},
                        prod_reg}) + rnd;
        if (shift_reg > lafir_pkg::SHIFT_LIMIT)
        begin
            delta_next = '0;
        end
        else
        begin
            delta_next = psum >>> shift_reg;
        end
    end

    // Add the delta and saturate the weight to 32 bits.
    always_comb
    begin
        wsum = $signed({{(SUMW + 1 - WW){w3_reg[WW-1]}}, w3_reg})
             + $signed({delta_reg[SUMW-1], delta_reg});
        if (wsum[SUMW:WW-1] == '0 || wsum[SUMW:WW-1] == '1)
        begin
            wsat = wsum[WW-1:0];
        end
        else if (wsum[SUMW])
        begin
            wsat = {1'b1, {(WW-1){1'b0}}};
        end
        else
        begin
            wsat = {1'b0, {(WW-1){1'b1}}};
        end
    end

    // Pipeline payload and accumulator.
    always_ff @(posedge clk)
    begin
        k1_reg    <= k_reg;
        k2_reg    <= k1_reg;
        k3_reg    <= k2_reg;
        w2_reg    <= $signed(w_rd);
        w3_reg    <= w2_reg;
        prod_reg  <= prod_next;
        delta_reg <= delta_next;
        if (cmd.load)
        begin
            d_reg   <= $signed(in_data[IN_W_HI:SW]);
            acc_reg <= '0;
        end
        else if (v2_reg && !m2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.gain_mul)
        begin
            ge_reg <= ge_next;
        end
        if (cmd.finish)
        begin
            y_reg <= y_next;
            e_reg <= e_next;
        end
    end

    // Round y to an integer and saturate to 16 bits; form the error.
    always_comb
    begin
        acc_rnd = acc_reg + (ACC_W'(1) << (lafir_pkg::FRAC_W - 1));
        yfull   = acc_rnd[ACC_W-1:lafir_pkg::FRAC_W];
        if (yfull[YF_W-1:SW-1] == '0 || yfull[YF_W-1:SW-1] == '1)
        begin
            y_next = yfull[SW-1:0];
        end
        else if (yfull[YF_W-1])
        begin
            y_next = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            y_next = {1'b0, {(SW-1){1'b1}}};
        end
        e_next  = $signed({d_reg[SW-1], d_reg}) - $signed({y_next[SW-1], y_next});
        ge_next = $signed({1'b0, gain_reg}) * e_reg;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{(lafir_pkg::OUT_W - SW - EW){1'b0}}, e_reg, y_reg};

    // Status.
    assign sts.last      = (k_reg == K_LAST);
    assign sts.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign sts.out_busy  = out_valid_reg && !out_ready;

endmodule

`default_nettype wire

// File: tb/lafir_tb_pkg.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR scoreboard
// Bit-exact prediction of the filter output and error for every accepted input
// beat, and an in-order comparison against the beats that leave the block.
// ----------------------------------------------------------------------------
package lafir_tb_pkg;

    import lafir_pkg::*;

    localparam int TAPS = 500;

    // One predicted output beat; packed in the same order as the output tdata.
    typedef struct packed {
        logic [ERR_W-1:0]    err;
        logic [SAMPLE_W-1:0] y;
    } fir_result_t;

    class lms_scoreboard;

        // Predictor state: Q7.24 weights, circular delay line and step size.
        int          weights [TAPS];
        shortint     history [TAPS];
        int          head;
        int          gain  = GAIN_RESET;
        int          shift = SHIFT_RESET;
        fir_result_t awaited [$];
        int unsigned failures;

        // Register writes to an unused index leave the step size alone.
        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_STEP_GAIN)
                gain = val;
            else if (idx == CFG_STEP_SHIFT)
                shift = val[SHIFT_W-1:0];
        endfunction

        // Push a sample, form y and the error, then adapt every weight.
        function void take_sample(logic signed [SAMPLE_W-1:0] x,
                                  logic signed [SAMPLE_W-1:0] d);
            longint      acc;
            longint      y;
            longint      e;
            longint      rnd;
            longint      p;
            longint      w;
            int          k;
            int          idx;
            fir_result_t res;

            history[head] = x;

            // Filter output with the weights from before this update.
            acc = 0;
            for (k = 0; k < TAPS; k++)
            begin
                idx = (head + TAPS - k) % TAPS;
                acc += longint'(weights[k]) * longint'(history[idx]);
            end
            y = (acc + (longint'(1) << 23)) >>> FRAC_W;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            e = longint'(d) - y;

            // Weight update, rounded half up, each weight saturated to 32 bits.
            rnd = (shift != 0) ? (longint'(1) << (shift - 1)) : 0;
            for (k = 0; k < TAPS; k++)
            begin
                idx = (head + TAPS - k) % TAPS;
                p = longint'(gain) * e * longint'(history[idx]);
                w = longint'(weights[k]) + ((p + rnd) >>> shift);
                if (w > 64'sd2147483647)
                    w = 64'sd2147483647;
                if (w < -64'sd2147483648)
                    w = -64'sd2147483648;
                weights[k] = int'(w);
            end

            head = (head + 1) % TAPS;

            res.y   = y[SAMPLE_W-1:0];
            res.err = e[ERR_W-1:0];
            awaited.push_back(res);
        endfunction

        // Compare one output beat with the oldest prediction.
        function void check_output(logic [OUT_W-1:0] data);
            fir_result_t want;
            if (awaited.size() == 0)
            begin
                $error("output beat with no sample waiting: tdata %h", data);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (data[SAMPLE_W-1:0] !== want.y)
            begin
                $error("filter_out: expected %0d, got %0d",
                       $signed(want.y), $signed(data[SAMPLE_W-1:0]));
                failures++;
            end
            if (data[SAMPLE_W +: ERR_W] !== want.err)
            begin
                $error("error_out: expected %0d, got %0d",
                       $signed(want.err), $signed(data[SAMPLE_W +: ERR_W]));
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

    endclass

endpackage

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// LMS adaptive FIR testbench
// Drives sample beats in random bursts through several step-size settings,
// stalls the output side on its own pattern, and checks every output beat
// against a bit-exact prediction held in the scoreboard.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lafir_pkg::*;
    import lafir_tb_pkg::*;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int          BEAT_CYCLES = 2 * TAPS + 11;
    localparam int          END_SLACK   = BEAT_CYCLES + 100;
    localparam int          LONG_HOLD   = 6000;
    localparam int unsigned ITEMS       = 590;
    localparam int unsigned CYCLE_LIMIT = 10_000_000;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = '0;
    logic [CFG_W-1:0]     cfg_wdata     = '0;

    lms_scoreboard sb = new;
    int unsigned   results_seen = 0;
    int unsigned   cycle_count  = 0;
    int            burst_left   = 0;

    lms_adaptive_fir #(
        .TAPS (TAPS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock, 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // Every output beat is checked as it is taken.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_output(m_axis_tdata);
            results_seen <= results_seen + 1;
        end
    end

    // Output side stalls in segments: always ready, coin flip, mostly stalled
    // or fully stalled. Twice it holds off long while samples are offered,
    // so the block fills up and drops its input ready.
    initial
    begin : receiver
        int seg;
        int mode;
        int holds;
        holds = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = (mode == 3) ? $urandom_range(1, 1500) : $urandom_range(20, 3000);
            repeat (seg)
            begin
                @(negedge clk);
                if (holds < 2 && results_seen >= 100 + 300 * holds && s_axis_tvalid)
                begin
                    holds++;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= 1'b0;
                endcase
            end
        end
    end

    // Offer one sample beat, opening a new burst after a random gap when the
    // current one is used up. Starts and ends at a falling edge.
    task automatic offer(input logic signed [SAMPLE_W-1:0] x,
                         input logic signed [SAMPLE_W-1:0] d);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 1200);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {d, x};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.take_sample(x, d);
        @(negedge clk);
    endtask

    // Stop offering and wait until every result is out and the block is
    // ready again, so the weight update of the last beat is done.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0 || !s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] corner_vals [5];
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] d;
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        int unsigned                issued;
        int                         plen;
        int                         phase;
        int                         r;
        int                         amp;
        int                         t;
        int                         gain;
        int                         shift;

        corner_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
        x1 = '0;
        x2 = '0;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        wait_idle();

        // Field extremes with the step size from reset.
        offer(16'sd0, 16'sd0);
        offer(16'sd32767, 16'sd32767);
        offer(-16'sd32768, -16'sd32768);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd1, -16'sd1);

        // Writes to unimplemented registers must change nothing.
        wait_idle();
        write_reg(CFG_SPARE_A, 16'hFFFF);
        write_reg(CFG_SPARE_B, 16'h0000);
        offer(-16'sd1, 16'sd1);
        offer(16'sd12345, -16'sd4321);

        // Full gain, no shift: weights and output run into saturation.
        // Upper data bits of the shift write are dropped by the register.
        wait_idle();
        write_reg(CFG_STEP_GAIN, 16'hFFFF);
        write_reg(CFG_STEP_SHIFT, 16'hFFC0);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd32767, 16'sd32767);
        offer(-16'sd32768, -16'sd32768);
        offer(16'sd32767, 16'sd0);

        // Zero gain freezes the saturated weights.
        wait_idle();
        write_reg(CFG_STEP_GAIN, 16'h0000);
        offer(16'sd1000, -16'sd1000);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd0, 16'sd5);

        // Largest shift, then a shift just under the shift limit.
        wait_idle();
        write_reg(CFG_STEP_GAIN, 16'hFFFF);
        write_reg(CFG_STEP_SHIFT, 16'hFFFF);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd32768, 16'sd32767);
        offer(16'sd300, -16'sd200);
        wait_idle();
        write_reg(CFG_STEP_SHIFT, 16'd48);
        offer(16'sd32767, -16'sd32768);
        offer(-16'sd5, 16'sd7);
        issued = 21;

        // Random phases, each with its own step size. Most samples follow a
        // short fixed echo path plus noise so the filter has something to
        // learn; the rest is raw noise and corner values.
        phase = 0;
        while (issued < ITEMS)
        begin
            case (phase % 5)
                0:
                begin
                    gain  = $urandom_range(1, 255);
                    shift = $urandom_range(18, 24);
                end
                1:
                begin
                    gain  = $urandom_range(0, 65535);
                    shift = $urandom_range(0, 63);
                end
                2:
                begin
                    gain  = 65535;
                    shift = $urandom_range(0, 1) ? 0 : 63;
                end
                3:
                begin
                    gain  = $urandom_range(0, 1);
                    shift = $urandom_range(0, 1) ? 47 : 3;
                end
                default:
                begin
                    gain  = $urandom_range(1, 4095);
                    shift = $urandom_range(20, 30);
                end
            endcase

            wait_idle();
            if ($urandom_range(0, 1))
            begin
                write_reg(CFG_STEP_GAIN, CFG_W'(gain));
                write_reg(CFG_STEP_SHIFT, CFG_W'(($urandom() & 32'hFFC0) | shift));
            end
            else
            begin
                write_reg(CFG_STEP_SHIFT, CFG_W'(($urandom() & 32'hFFC0) | shift));
                write_reg(CFG_STEP_GAIN, CFG_W'(gain));
            end

            // The last phase is cut short so the run ends on the item count.
            plen = $urandom_range(30, 70);
            if (plen > int'(ITEMS - issued))
                plen = int'(ITEMS - issued);
            amp  = $urandom_range(0, 6);
            repeat (plen)
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                begin
                    x = SAMPLE_W'($urandom());
                    x = x >>> amp;
                    t = (int'(x) >>> 1) + (int'(x1) >>> 2) - (int'(x2) >>> 3)
                        + int'($urandom_range(0, 16)) - 8;
                    if (t > 32767)
                        t = 32767;
                    if (t < -32768)
                        t = -32768;
                    d = t[SAMPLE_W-1:0];
                end
                else if (r < 90)
                begin
                    x = SAMPLE_W'($urandom());
                    d = SAMPLE_W'($urandom());
                end
                else
                begin
                    x = corner_vals[$urandom_range(0, 4)];
                    d = corner_vals[$urandom_range(0, 4)];
                end
                x2 = x1;
                x1 = x;
                offer(x, d);
                issued++;
            end
            phase++;
        end

        // Drain, then give the block time to show any stray beat.
        wait_idle();
        repeat (END_SLACK) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/lafir_pkg.sv
hdl/lafir_ram.sv
hdl/lafir_ctrl.sv
hdl/lafir_dp.sv
hdl/lms_adaptive_fir.sv
tb/lafir_tb_pkg.sv
tb/tb.sv
